// ===== sv/gvq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gvq_pkg
// Shared constants, codes and types of the guest virtual interrupt slot queue.
// ----------------------------------------------------------------------------
package gvq_pkg;

   localparam int GUESTS      = 4;
   localparam int SLOTS       = 128;
   localparam int ROW_AW      = (GUESTS > 1) ? $clog2(GUESTS) : 1;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int ENTRY_AW    = ROW_AW + SLOT_W;
   localparam int ENTRY_DEPTH = GUESTS * SLOTS;

   localparam int GUEST_ID_W  = 2;
   localparam int IRQ_W       = 10;
   localparam int STATUS_W    = 2;
   localparam int SLOT_OUT_W  = 7;

   localparam logic OP_INJECT = 1'b0;
   localparam logic OP_TAKE   = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef logic [ROW_AW-1:0]   row_addr_type;
   typedef logic [SLOT_W-1:0]   slot_idx_type;
   typedef logic [ENTRY_AW-1:0] entry_addr_type;
   typedef logic [SLOTS-1:0]    row_type;

   // same bit order as the stored word: virtual low, then physical, then flag
   typedef struct packed {
      logic             hw_linked;
      logic [IRQ_W-1:0] physical_irq;
      logic [IRQ_W-1:0] virtual_irq;
   } entry_type;

   typedef struct packed {
      logic         found;
      slot_idx_type index;
      row_type      onehot;
   } find_type;

   typedef struct packed {
      logic         en;
      row_addr_type addr;
      row_type      data;
   } row_wr_type;

   typedef struct packed {
      logic           en;
      entry_addr_type addr;
      entry_type      data;
   } entry_wr_type;

endpackage
`default_nettype wire

// ===== sv/guest_virtual_irq_slot_queue_core.sv =====
`default_nettype none
// Each item goes through three steps: the valid-row read, the search with row
// write-back, and the entry read; its result is then registered for output,
// which waits while rsp is stalled. No new item is taken before that.
// A finished result waits in the output register; a new item is taken meanwhile.
// Reset clears the per-guest row flags at once, so every slot reads free; no
// clearing pass is needed and the entry memory is left as it is.
// ----------------------------------------------------------------------------
// guest_virtual_irq_slot_queue_core
// Per-guest pending virtual interrupt slots: inject into lowest free slot,
// take the lowest valid slot.
// ----------------------------------------------------------------------------
module guest_virtual_irq_slot_queue_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_op,
   input  logic [gvq_pkg::GUEST_ID_W-1:0]      req_guest_id,
   input  logic [gvq_pkg::IRQ_W-1:0]           req_virtual_irq,
   input  logic [gvq_pkg::IRQ_W-1:0]           req_physical_irq,
   input  logic                                req_hw_linked,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [gvq_pkg::STATUS_W-1:0]        rsp_status,
   output logic [gvq_pkg::SLOT_OUT_W-1:0]      rsp_slot_index,
   output logic [gvq_pkg::IRQ_W-1:0]           rsp_taken_virtual_irq,
   output logic [gvq_pkg::IRQ_W-1:0]           rsp_taken_physical_irq,
   output logic                                rsp_taken_hw_linked
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SRCH = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]                   state_ff, state_in;
   logic                         req_xfer;
   logic                         load_rsp;

   logic                         op_ff;
   gvq_pkg::row_addr_type        row_addr_ff;
   logic                         in_range_ff;
   gvq_pkg::entry_type           entry_ff;

   logic [gvq_pkg::STATUS_W-1:0] status_ff;
   gvq_pkg::slot_idx_type        slot_ff;
   logic                         take_ok_ff;

   gvq_pkg::row_type             row_bits;
   gvq_pkg::row_type             search_vec;
   gvq_pkg::find_type            find;
   logic                         hit;
   gvq_pkg::row_wr_type          row_wr;
   gvq_pkg::entry_wr_type        entry_wr;
   logic                         entry_rd_en;
   gvq_pkg::entry_addr_type      entry_addr;
   gvq_pkg::entry_type           entry_rd;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [gvq_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [gvq_pkg::SLOT_OUT_W-1:0] rsp_slot_ff;
   gvq_pkg::entry_type           rsp_entry_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid & ~req_stall;
   assign load_rsp  = (state_ff == S_DONE) & (~rsp_valid_ff | ~rsp_stall);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) state_in = S_SRCH;
         end
         S_SRCH: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (load_rsp) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item capture on input transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff                 <= req_op;
         row_addr_ff           <= gvq_pkg::row_addr_type'(req_guest_id);
         in_range_ff           <= (32'(req_guest_id) < gvq_pkg::GUESTS);
         entry_ff.virtual_irq  <= req_virtual_irq;
         entry_ff.physical_irq <= req_physical_irq;
         entry_ff.hw_linked    <= req_hw_linked;
      end
   end

   gvq_valid_ram u_valid_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_xfer),
      .rd_addr (gvq_pkg::row_addr_type'(req_guest_id)),
      .row_wr  (row_wr),
      .rd_row  (row_bits)
   );

   // inject looks for a clear bit, take for a set bit
   assign search_vec = (op_ff == gvq_pkg::OP_TAKE) ? row_bits : ~row_bits;

   gvq_find_first u_find (
      .vec    (search_vec),
      .result (find)
   );

   assign hit        = (state_ff == S_SRCH) & in_range_ff & find.found;
   assign entry_addr = {row_addr_ff, find.index};

   // the chosen bit flips: set on inject, cleared on take
   assign row_wr.en   = hit;
   assign row_wr.addr = row_addr_ff;
   assign row_wr.data = row_bits ^ find.onehot;

   assign entry_wr.en   = hit & (op_ff == gvq_pkg::OP_INJECT);
   assign entry_wr.addr = entry_addr;
   assign entry_wr.data = entry_ff;

   assign entry_rd_en = hit & (op_ff == gvq_pkg::OP_TAKE);

   gvq_entry_ram u_entry_ram (
      .clock    (clock),
      .entry_wr (entry_wr),
      .rd_en    (entry_rd_en),
      .rd_addr  (entry_addr),
      .rd_data  (entry_rd)
   );

   always_ff @(posedge clock) begin
      if (state_ff == S_SRCH) begin
         slot_ff    <= hit ? find.index : '0;
         take_ok_ff <= entry_rd_en;
         if (hit) begin
            status_ff <= gvq_pkg::STATUS_OK;
         end else if (op_ff == gvq_pkg::OP_TAKE) begin
            status_ff <= gvq_pkg::STATUS_EMPTY;
         end else begin
            status_ff <= gvq_pkg::STATUS_FULL;
         end
      end
   end

   assign rsp_valid_in = load_rsp | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_slot_ff   <= gvq_pkg::SLOT_OUT_W'(slot_ff);
         rsp_entry_ff  <= take_ok_ff ? entry_rd : '0;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_slot_index         = rsp_slot_ff;
   assign rsp_taken_virtual_irq  = rsp_entry_ff.virtual_irq;
   assign rsp_taken_physical_irq = rsp_entry_ff.physical_irq;
   assign rsp_taken_hw_linked    = rsp_entry_ff.hw_linked;

endmodule
`default_nettype wire

// ===== sv/gvq_find_first.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gvq_find_first
// Lowest set bit of a slot row: one-hot mask, binary index and found flag.
// ----------------------------------------------------------------------------
module gvq_find_first (
   input  gvq_pkg::row_type  vec,
   output gvq_pkg::find_type result
);

   gvq_pkg::row_type      lowbit;
   gvq_pkg::slot_idx_type index;

   // isolate lowest set bit with a single wide add
   assign lowbit = vec & ((~vec) + gvq_pkg::row_type'(1));

   always_comb begin
      index = '0;
      for (int b = 0; b < gvq_pkg::SLOT_W; b++) begin
         for (int i = 0; i < gvq_pkg::SLOTS; i++) begin
            if (((i >> b) & 1) == 1) begin
               index[b] = index[b] | lowbit[i];
            end
         end
      end
   end

   assign result.found  = |vec;
   assign result.index  = index;
   assign result.onehot = lowbit;

endmodule
`default_nettype wire

// ===== sv/gvq_valid_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gvq_valid_ram
// Slot valid bits, one row per guest, in a synchronous memory with registered read.
// Rows never written since reset read as all clear.
// ----------------------------------------------------------------------------
module gvq_valid_ram (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  gvq_pkg::row_addr_type rd_addr,
   input  gvq_pkg::row_wr_type   row_wr,
   output gvq_pkg::row_type      rd_row
);

   gvq_pkg::row_type             rows [0:gvq_pkg::GUESTS-1];
   logic [gvq_pkg::GUESTS-1:0]   row_live_ff;
   gvq_pkg::row_type             rd_data_ff;
   logic                         rd_live_ff;

   always_ff @(posedge clock) begin
      if (row_wr.en) begin
         rows[row_wr.addr] <= row_wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= rows[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_live_ff <= '0;
         rd_live_ff  <= 1'b0;
      end else begin
         if (row_wr.en) begin
            row_live_ff[row_wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_live_ff <= row_live_ff[rd_addr];
         end
      end
   end

   assign rd_row = rd_live_ff ? rd_data_ff : '0;

endmodule
`default_nettype wire

// ===== sv/gvq_entry_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gvq_entry_ram
// Slot payload store: virtual number, physical number and link flag per slot.
// ----------------------------------------------------------------------------
module gvq_entry_ram (
   input  logic                    clock,
   input  gvq_pkg::entry_wr_type   entry_wr,
   input  logic                    rd_en,
   input  gvq_pkg::entry_addr_type rd_addr,
   output gvq_pkg::entry_type      rd_data
);

   gvq_pkg::entry_type mem [0:gvq_pkg::ENTRY_DEPTH-1];
   gvq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (entry_wr.en) begin
         mem[entry_wr.addr] <= entry_wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== sv/gvq_port_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gvq_port_checker
// Port-level checks on the slot queue core, attached by bind.
// ----------------------------------------------------------------------------
module gvq_port_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [gvq_pkg::STATUS_W-1:0]        rsp_status,
   input  logic [gvq_pkg::SLOT_OUT_W-1:0]      rsp_slot_index,
   input  logic [gvq_pkg::IRQ_W-1:0]           rsp_taken_virtual_irq,
   input  logic [gvq_pkg::IRQ_W-1:0]           rsp_taken_physical_irq,
   input  logic                                rsp_taken_hw_linked
);

   // nothing to deliver right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // one item in flight: an input transfer closes the input side
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second item taken while one is in flight");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == gvq_pkg::STATUS_OK ||
                     rsp_status == gvq_pkg::STATUS_FULL ||
                     rsp_status == gvq_pkg::STATUS_EMPTY))
      else $error("undefined status code");

   // failed inject or take carries no slot and no entry
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != gvq_pkg::STATUS_OK) |->
         (rsp_slot_index == '0 && rsp_taken_virtual_irq == '0 &&
          rsp_taken_physical_irq == '0 && !rsp_taken_hw_linked))
      else $error("failed result with nonzero fields");

   // a stalled result stays offered and unchanged
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_slot_index) &&
          $stable(rsp_taken_virtual_irq) && $stable(rsp_taken_physical_irq) &&
          $stable(rsp_taken_hw_linked)))
      else $error("stalled result changed");

endmodule

bind guest_virtual_irq_slot_queue_core gvq_port_checker u_gvq_port_checker (.*);
`default_nettype wire

// ===== dv/irq_slot_check_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// irq_slot_check_pkg
// Scoreboard for the guest virtual interrupt slot queue: keeps its own copy of
// every guest's slot table, predicts the result of each accepted request and
// checks results in order against those predictions.
// ----------------------------------------------------------------------------
package irq_slot_check_pkg;

   import gvq_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [SLOT_OUT_W-1:0] slot_index;
      entry_type             taken;
   } result_type;

   class slot_queue_checker;

      bit         occupied [GUESTS][SLOTS];
      entry_type  stored   [GUESTS][SLOTS];
      result_type awaited  [$];
      int         errors;

      function new();
         errors = 0;
      endfunction

      function int fill_level(int guest);
         int n;
         n = 0;
         for (int s = 0; s < SLOTS; s++) begin
            if (occupied[guest][s]) n++;
         end
         return n;
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction

      // apply one accepted request to the tables and queue its result
      function void note_request(logic op, logic [GUEST_ID_W-1:0] guest, entry_type item);
         result_type r;
         bit         hit;
         r   = '0;
         hit = 1'b0;
         if (int'(guest) >= GUESTS) begin
            r.status = (op == OP_TAKE) ? STATUS_EMPTY : STATUS_FULL;
         end else if (op == OP_INJECT) begin
            r.status = STATUS_FULL;
            for (int s = 0; s < SLOTS && !hit; s++) begin
               if (!occupied[guest][s]) begin
                  occupied[guest][s] = 1'b1;
                  stored[guest][s]   = item;
                  r.status           = STATUS_OK;
                  r.slot_index       = SLOT_OUT_W'(s);
                  hit                = 1'b1;
               end
            end
         end else begin
            r.status = STATUS_EMPTY;
            for (int s = 0; s < SLOTS && !hit; s++) begin
               if (occupied[guest][s]) begin
                  occupied[guest][s] = 1'b0;
                  r.status           = STATUS_OK;
                  r.slot_index       = SLOT_OUT_W'(s);
                  r.taken            = stored[guest][s];
                  hit                = 1'b1;
               end
            end
         end
         awaited.push_back(r);
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_result(result_type got);
         result_type want;
         if (awaited.size() == 0) begin
            report($sformatf("result with none awaited, status %0d slot %0d",
                             got.status, got.slot_index));
            return;
         end
         want = awaited.pop_front();
         if (got.status !== want.status)
            report($sformatf("status got %0d expected %0d", got.status, want.status));
         if (got.slot_index !== want.slot_index)
            report($sformatf("slot_index got %0d expected %0d",
                             got.slot_index, want.slot_index));
         if (got.taken.virtual_irq !== want.taken.virtual_irq)
            report($sformatf("taken_virtual_irq got %0d expected %0d",
                             got.taken.virtual_irq, want.taken.virtual_irq));
         if (got.taken.physical_irq !== want.taken.physical_irq)
            report($sformatf("taken_physical_irq got %0d expected %0d",
                             got.taken.physical_irq, want.taken.physical_irq));
         if (got.taken.hw_linked !== want.taken.hw_linked)
            report($sformatf("taken_hw_linked got %0d expected %0d",
                             got.taken.hw_linked, want.taken.hw_linked));
      endtask

   endclass

endpackage

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives inject and take requests into the slot queue under changing sender
// gaps and receiver stalls, including a full fill and drain of one guest and a
// long receiver hold-off, and checks every result against the scoreboard.
// ----------------------------------------------------------------------------
module testbench;

   import gvq_pkg::*;
   import irq_slot_check_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic                  req_op           = OP_INJECT;
   logic [GUEST_ID_W-1:0] req_guest_id     = '0;
   logic [IRQ_W-1:0]      req_virtual_irq  = '0;
   logic [IRQ_W-1:0]      req_physical_irq = '0;
   logic                  req_hw_linked    = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [SLOT_OUT_W-1:0] rsp_slot_index;
   logic [IRQ_W-1:0]      rsp_taken_virtual_irq;
   logic [IRQ_W-1:0]      rsp_taken_physical_irq;
   logic                  rsp_taken_hw_linked;

   slot_queue_checker queue_check = new();
   result_type        seen_rsp;
   int                send_idle_pct = 0;
   int                rsp_stall_pct = 0;
   int                hold_left     = 0;
   int                cycle_count   = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   guest_virtual_irq_slot_queue_core dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_op                 (req_op),
      .req_guest_id           (req_guest_id),
      .req_virtual_irq        (req_virtual_irq),
      .req_physical_irq       (req_physical_irq),
      .req_hw_linked          (req_hw_linked),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_status             (rsp_status),
      .rsp_slot_index         (rsp_slot_index),
      .rsp_taken_virtual_irq  (rsp_taken_virtual_irq),
      .rsp_taken_physical_irq (rsp_taken_physical_irq),
      .rsp_taken_hw_linked    (rsp_taken_hw_linked)
   );

   // receiver side: random stalls, or a long hold-off counted down here
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else if (!reset && rsp_valid && !rsp_stall) begin
         seen_rsp.status             = rsp_status;
         seen_rsp.slot_index         = rsp_slot_index;
         seen_rsp.taken.virtual_irq  = rsp_taken_virtual_irq;
         seen_rsp.taken.physical_irq = rsp_taken_physical_irq;
         seen_rsp.taken.hw_linked    = rsp_taken_hw_linked;
         queue_check.check_result(seen_rsp);
      end
   end

   task send_item(input logic op, input logic [GUEST_ID_W-1:0] guest,
                  input logic [IRQ_W-1:0] virt, input logic [IRQ_W-1:0] phys,
                  input logic hw);
      entry_type item;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_op           = op;
      req_guest_id     = guest;
      req_virtual_irq  = virt;
      req_physical_irq = phys;
      req_hw_linked    = hw;
      req_valid        = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      item.virtual_irq  = virt;
      item.physical_irq = phys;
      item.hw_linked    = hw;
      queue_check.note_request(op, guest, item);
   endtask

   task send_random(input logic op, input logic [GUEST_ID_W-1:0] guest);
      send_item(op, guest, IRQ_W'($urandom), IRQ_W'($urandom), 1'($urandom));
   endtask

   task mixed_item(input int take_pct);
      send_random(($urandom_range(99) < take_pct) ? OP_TAKE : OP_INJECT,
                  GUEST_ID_W'($urandom_range(GUESTS - 1)));
   endtask

   // drop valid, then hold until every transfer has its result back
   task wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (queue_check.outstanding() != 0) @(posedge clock);
   endtask

   initial begin
      int take_pct [4];
      int guest;
      take_pct = '{30, 50, 70, 45};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes, empty takes, refill of a freed low slot
      send_item(OP_INJECT, 2'd0, 10'd0, 10'd0, 1'b0);
      send_item(OP_INJECT, 2'd0, 10'd1023, 10'd1023, 1'b1);
      send_item(OP_INJECT, 2'd1, 10'd1023, 10'd0, 1'b1);
      send_item(OP_INJECT, 2'd2, 10'd0, 10'd1023, 1'b0);
      send_item(OP_INJECT, 2'd3, 10'h155, 10'h2aa, 1'b1);
      send_item(OP_INJECT, 2'd3, 10'h2aa, 10'h155, 1'b0);
      send_item(OP_TAKE, 2'd0, 10'd1023, 10'd1023, 1'b1);
      send_item(OP_TAKE, 2'd0, 10'd0, 10'd0, 1'b0);
      send_item(OP_TAKE, 2'd0, 10'd0, 10'd0, 1'b0);
      send_item(OP_TAKE, 2'd1, 10'd0, 10'd0, 1'b0);
      send_item(OP_TAKE, 2'd1, 10'd0, 10'd0, 1'b0);
      send_item(OP_TAKE, 2'd2, 10'd0, 10'd0, 1'b0);
      send_item(OP_TAKE, 2'd3, 10'd0, 10'd0, 1'b0);
      send_item(OP_TAKE, 2'd3, 10'd0, 10'd0, 1'b0);
      send_item(OP_TAKE, 2'd3, 10'd0, 10'd0, 1'b0);
      send_item(OP_TAKE, 2'd2, 10'd0, 10'd0, 1'b0);
      send_item(OP_INJECT, 2'd1, 10'd7, 10'd8, 1'b1);
      send_item(OP_INJECT, 2'd1, 10'd9, 10'd10, 1'b0);
      send_item(OP_INJECT, 2'd1, 10'd11, 10'd12, 1'b1);
      send_item(OP_TAKE, 2'd1, 10'd0, 10'd0, 1'b0);
      send_item(OP_INJECT, 2'd1, 10'd13, 10'd14, 1'b0);
      wait_drained();

      // random mixes under each idling pattern
      for (int mode = 0; mode < 4; mode++) begin
         send_idle_pct = (mode == 1) ? 60 : (mode == 3) ? 15 : 0;
         rsp_stall_pct = (mode == 2) ? 60 : (mode == 3) ? 15 : 0;
         repeat (60) mixed_item(take_pct[mode]);
         wait_drained();
      end

      // fill one guest to the top, overflow it, then drain it past empty
      guest = $urandom_range(GUESTS - 1);
      while (queue_check.fill_level(guest) < SLOTS)
         send_random(OP_INJECT, GUEST_ID_W'(guest));
      repeat (3) send_random(OP_INJECT, GUEST_ID_W'(guest));
      while (queue_check.fill_level(guest) > 0)
         send_random(OP_TAKE, GUEST_ID_W'(guest));
      repeat (2) send_random(OP_TAKE, GUEST_ID_W'(guest));
      wait_drained();

      // receiver holds off while requests keep coming, so the input backs up
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      @(posedge clock);
      hold_left = HOLD_CYCLES;
      repeat (24) mixed_item(40);
      wait_drained();

      repeat (20) @(posedge clock);
      if (queue_check.errors == 0 && queue_check.outstanding() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
